### rtl/core/iqtf_pkg.sv
// Shared types and constants for the indexed tag queue.
package iqtf_pkg;

  localparam int CAPACITY = 64;
  localparam int TAG_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CQ_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_GIVE = 2'd0,
    OP_SEAT = 2'd1,
    OP_KICK = 2'd2,
    OP_MTF  = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [TAG_W-1:0] tag;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] qcount;
    logic [CNT_W-1:0] fcount;
  } stat_t;

endpackage

### rtl/core/iqtf_ram.sv
// Generic single-port-write RAM with registered read.
module iqtf_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/iqtf_front.sv
// Command front end: accepts and decodes commands into a short queue.
module iqtf_front import iqtf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       opcode,
  input  logic [TAG_W-1:0] tag_id,
  output logic             busy,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  logic             cmd_pop
);

  localparam int PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CW = $clog2(CQ_DEPTH + 1);

  cmd_t             slots [CQ_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CQ_CW-1:0] count;
  logic             push;
  logic             pop;

  assign busy      = (count == CQ_CW'(CQ_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{op: op_t'(opcode), tag: tag_id};
    end
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CQ_CW'(push) - CQ_CW'(pop);
    end
  end

endmodule

### rtl/core/iqtf_back.sv
// Execution back end: link lists, free ring and result registers.
module iqtf_back import iqtf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  output logic             done,
  output logic [TAG_W-1:0] tag_out,
  output logic             success,
  output logic [CNT_W-1:0] queue_length,
  output stat_t            stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LINK
  } state_t;

  state_t              state, state_next;
  cmd_t                cmd_q;
  logic                mark_q;
  logic [TAG_W-1:0]    head, head_next;
  logic [TAG_W-1:0]    tail, tail_next;
  logic [CNT_W-1:0]    qcount, qcount_next;
  logic [CNT_W-1:0]    fcount, fcount_next;
  logic [TAG_W-1:0]    rptr, rptr_next;
  logic [TAG_W-1:0]    wptr, wptr_next;
  logic                wrapped, wrapped_next;
  logic [CAPACITY-1:0] marks, marks_next;

  logic             emit;
  logic [TAG_W-1:0] res_tag;
  logic             res_ok;

  logic             nx_we, pv_we, fr_we;
  logic [TAG_W-1:0] nx_waddr, nx_wdata, nx_raddr, nx_rdata;
  logic [TAG_W-1:0] pv_waddr, pv_wdata, pv_rdata;
  logic [TAG_W-1:0] fr_waddr, fr_wdata, fr_rdata;
  logic [TAG_W-1:0] fr_val, t, p, n;

  iqtf_ram #(.W(TAG_W), .D(CAPACITY)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata)
  );

  iqtf_ram #(.W(TAG_W), .D(CAPACITY)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(cmd.tag), .rdata(pv_rdata)
  );

  // entries not yet rewritten since reset are read as their own index via fr_val
  iqtf_ram #(.W(TAG_W), .D(CAPACITY)) u_free (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(rptr), .rdata(fr_rdata)
  );

  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign nx_raddr = (cmd.op == OP_SEAT) ? head : cmd.tag;
  assign t        = cmd_q.tag;
  assign p        = pv_rdata;
  assign n        = nx_rdata;
  assign fr_val   = (wrapped || (rptr < wptr)) ? fr_rdata : rptr;
  assign stat     = '{qcount: qcount, fcount: fcount};

  always_comb begin
    state_next   = state;
    head_next    = head;
    tail_next    = tail;
    qcount_next  = qcount;
    fcount_next  = fcount;
    rptr_next    = rptr;
    wptr_next    = wptr;
    wrapped_next = wrapped;
    marks_next   = marks;
    emit         = 1'b0;
    res_tag      = '0;
    res_ok       = 1'b0;
    nx_we        = 1'b0;
    nx_waddr     = '0;
    nx_wdata     = '0;
    pv_we        = 1'b0;
    pv_waddr     = '0;
    pv_wdata     = '0;
    fr_we        = 1'b0;
    fr_waddr     = wptr;
    fr_wdata     = '0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        emit       = 1'b1;
        case (cmd_q.op)
          OP_GIVE: begin
            if (fcount != '0) begin
              res_ok  = 1'b1;
              res_tag = fr_val;
              if (qcount == '0) begin
                head_next = fr_val;
              end else begin
                nx_we    = 1'b1;
                nx_waddr = tail;
                nx_wdata = fr_val;
                pv_we    = 1'b1;
                pv_waddr = fr_val;
                pv_wdata = tail;
              end
              tail_next         = fr_val;
              marks_next[fr_val] = 1'b1;
              qcount_next       = qcount + CNT_W'(1);
              fcount_next       = fcount - CNT_W'(1);
              rptr_next = (rptr == TAG_W'(CAPACITY - 1)) ? '0 : rptr + TAG_W'(1);
            end
          end
          OP_SEAT: begin
            if (qcount != '0) begin
              res_ok  = 1'b1;
              res_tag = head;
              if (qcount > CNT_W'(1)) begin
                head_next = n;
              end
              marks_next[head] = 1'b0;
              qcount_next      = qcount - CNT_W'(1);
              fr_we            = 1'b1;
              fr_wdata         = head;
            end
          end
          default: begin
            // kick out and move to front share the unlink
            if (mark_q && (cmd_q.op == OP_KICK || t != head)) begin
              if (t == head) begin
                head_next = n;
              end else begin
                nx_we    = 1'b1;
                nx_waddr = p;
                nx_wdata = n;
              end
              if (t == tail) begin
                tail_next = p;
              end else begin
                pv_we    = 1'b1;
                pv_waddr = n;
                pv_wdata = p;
              end
              if (cmd_q.op == OP_KICK) begin
                res_ok        = 1'b1;
                marks_next[t] = 1'b0;
                qcount_next   = qcount - CNT_W'(1);
                fr_we         = 1'b1;
                fr_wdata      = t;
              end else begin
                emit       = 1'b0;
                state_next = S_LINK;
              end
            end
          end
        endcase
        if (fr_we) begin
          wptr_next   = (wptr == TAG_W'(CAPACITY - 1)) ? '0 : wptr + TAG_W'(1);
          fcount_next = fcount + CNT_W'(1);
          if (wptr == TAG_W'(CAPACITY - 1)) begin
            wrapped_next = 1'b1;
          end
        end
      end
      S_LINK: begin
        // relink the tag in front of the old head
        nx_we      = 1'b1;
        nx_waddr   = t;
        nx_wdata   = head;
        pv_we      = 1'b1;
        pv_waddr   = head;
        pv_wdata   = t;
        head_next  = t;
        emit       = 1'b1;
        res_ok     = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_q  <= cmd;
      mark_q <= marks[cmd.tag];
    end
    if (emit) begin
      tag_out      <= res_tag;
      success      <= res_ok;
      queue_length <= qcount_next;
    end
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      tail    <= '0;
      qcount  <= '0;
      fcount  <= CNT_W'(CAPACITY);
      rptr    <= '0;
      wptr    <= '0;
      wrapped <= 1'b0;
      marks   <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      tail    <= tail_next;
      qcount  <= qcount_next;
      fcount  <= fcount_next;
      rptr    <= rptr_next;
      wptr    <= wptr_next;
      wrapped <= wrapped_next;
      marks   <= marks_next;
      done    <= emit;
    end
  end

endmodule

### rtl/core/indexed_queue_with_tag_free_list.sv
// Top level of the indexed tag queue with free list.
//
//   channel   ports                                  handshake
//   command   opcode, tag_id                         start & !busy
//   result    tag_out, success, queue_length         done, one cycle
//
// Each command passes the back end in S_IDLE (link RAM read) and S_EXEC
// (update); a successful move to front adds S_LINK, a second write to each
// link RAM port. A two-word command queue lets new commands in meanwhile.
// Synchronous reset; no clearing pass, the first command can follow reset.
// The result receiver cannot stall; busy rises only when the queue is full.
module indexed_queue_with_tag_free_list import iqtf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       opcode,
  input  logic [TAG_W-1:0] tag_id,
  output logic             busy,
  output logic             done,
  output logic [TAG_W-1:0] tag_out,
  output logic             success,
  output logic [CNT_W-1:0] queue_length
);

  logic  cmd_valid;
  logic  cmd_pop;
  cmd_t  cmd;
  stat_t stat;

  iqtf_front u_front (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode), .tag_id(tag_id),
    .busy(busy), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  iqtf_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .done(done), .tag_out(tag_out), .success(success),
    .queue_length(queue_length), .stat(stat)
  );

  a_tag_conserve: assert property (@(posedge clk) disable iff (rst)
    (CNT_W + 1)'(stat.qcount) + (CNT_W + 1)'(stat.fcount) == (CNT_W + 1)'(CAPACITY))
    else $error("queued and free tags do not add up");

  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back results closer than two cycles");

  a_len_match: assert property (@(posedge clk) disable iff (rst)
    done |-> queue_length == stat.qcount)
    else $error("reported length differs from queue count");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !success) |-> tag_out == '0)
    else $error("refused command reports a tag");

endmodule
